@@ src/skt_pkg.sv @@
// ============================================================================
// Sorted key table package
// Shared constants, command and status codes, and the transaction types.
// ============================================================================
`default_nettype none

package skt_pkg;

    // Built size of the table.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CMD_W       = 3;
    localparam int POS_W       = 8;
    localparam int STAT_W      = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EXISTS = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } t_cell_op;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_cell_op                op;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } t_cell_ctl;

    // What the chain reports back to the controller.
    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] rd_key;
    } t_chain_stat;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

`default_nettype wire

@@ src/skt_cell.sv @@
// ============================================================================
// Sorted key table cell
// Holds one key, compares it with the broadcast key and shifts with its
// neighbors on insert and remove.
// ============================================================================
`default_nettype none

module skt_cell
    import skt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic                    i_valid,
    input  wire logic signed [KEY_W-1:0] i_left_key,
    input  wire logic                    i_left_less,
    input  wire logic signed [KEY_W-1:0] i_right_key,
    output logic signed [KEY_W-1:0]      o_key,
    output logic                         o_less,
    output logic                         o_eq
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    // Entries are sorted, so the less flags form a run from the first cell.
    assign o_less = i_valid && (r_key < i_ctl.key);
    assign o_eq   = i_valid && (r_key == i_ctl.key);
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            OP_INSERT: begin
                // The first cell not below the key takes it; cells after it
                // take their left neighbor.
                if (!o_less) begin
                    n_key = i_left_less ? i_ctl.key : i_left_key;
                end
            end
            OP_REMOVE: begin
                // From the matching cell onward, every cell pulls from the right.
                if (!o_less) begin
                    n_key = i_right_key;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

@@ src/skt_ctrl.sv @@
// ============================================================================
// Sorted key table controller
// Decodes commands, keeps the entry count and capacity, sequences dumps and
// drives the output register.
// ============================================================================
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire t_chain_stat      i_stat,
    output t_cell_ctl             o_ctl,
    output logic [IDX_W-1:0]      o_rd_addr
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_dump_idx, n_dump_idx;
    logic [CAP_W-1:0] r_capacity;
    logic             r_out_valid;
    t_out_item        r_out_item, n_out_item;
    logic             load_out;
    logic             out_free;
    logic             accept;
    logic             full;
    logic             dump_last;
    t_cell_op         op;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state == S_DUMP) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign full = (int'(r_count) >= int'(r_capacity)) || (int'(r_count) >= MAX_ENTRIES);
    assign dump_last = (int'(r_dump_idx) + 1) == int'(r_count);

    assign o_rd_addr = (r_state == S_DUMP) ? r_dump_idx : i_in_item.index[IDX_W-1:0];
    assign o_ctl     = '{op: op, key: i_in_item.key, count: r_count};

    // Next state.
    always_comb begin
        n_state    = r_state;
        n_dump_idx = r_dump_idx;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_item.cmd == CMD_DUMP && r_count != '0) begin
                    n_state    = S_DUMP;
                    n_dump_idx = '0;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_dump_idx = IDX_W'(r_dump_idx + 1'b1);
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: result item, cell operation and count update.
    always_comb begin
        load_out   = 1'b0;
        op         = OP_HOLD;
        n_count    = r_count;
        n_out_item = '{status: STAT_OK, found: 1'b0, value: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.cmd)
                        CMD_INSERT: begin
                            load_out = 1'b1;
                            if (full) begin
                                n_out_item.status = STAT_FULL;
                            end else if (i_stat.found) begin
                                n_out_item.status = STAT_EXISTS;
                            end else begin
                                op      = OP_INSERT;
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                        end
                        CMD_REMOVE: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                n_out_item.status = STAT_EMPTY;
                            end else if (!i_stat.found) begin
                                n_out_item.status = STAT_ABSENT;
                            end else begin
                                op      = OP_REMOVE;
                                n_count = CNT_W'(r_count - 1'b1);
                            end
                        end
                        CMD_SEARCH: begin
                            load_out         = 1'b1;
                            n_out_item.found = i_stat.found;
                        end
                        CMD_READ: begin
                            load_out = 1'b1;
                            if (int'(i_in_item.index) < int'(r_count)) begin
                                n_out_item.value = i_stat.rd_key;
                            end else begin
                                n_out_item.status = STAT_BADPOS;
                            end
                        end
                        CMD_DUMP: begin
                            // A filled table is streamed from the dump state.
                            if (r_count == '0) begin
                                load_out          = 1'b1;
                                n_out_item.status = STAT_EMPTY;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    load_out         = 1'b1;
                    n_out_item.value = i_stat.rd_key;
                    n_out_item.last  = dump_last;
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump_idx <= n_dump_idx;
        if (load_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ src/sorted_key_table_core.sv @@
// ============================================================================
// Sorted key table core
// Keeps distinct signed keys in ascending order in a chain of shifting cells
// and answers insert, remove, search, read and dump commands.
// ============================================================================
//
//  Channel | Signals                               | Direction
//  --------+---------------------------------------+-----------
//  in      | i_in_valid, o_in_stall, i_in_item     | command in
//  out     | o_out_valid, i_out_stall, o_out_item  | result out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data  | capacity write
//
//  For insert, remove, search and read, every cell compares its key with the
//  command key at once and shifts with its neighbors in the same cycle. A
//  dump streams the entries one after another through the single shared
//  read mux and output register, pausing while the output stalls. Reset
//  is synchronous and clears the count, capacity and control; keys need no
//  clearing. A stalled output holds its transaction and holds off new commands.
//
`default_nettype none

module sorted_key_table_core
    import skt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    t_cell_ctl               ctl;
    t_chain_stat             stat;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [KEY_W-1:0] keys [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  less;
    logic [MAX_ENTRIES-1:0]  eq;
    logic [MAX_ENTRIES-1:0]  valid;

    // Command decode, count and capacity, dump sequencing, output register.
    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_ctl       (ctl),
        .o_rd_addr   (rd_addr)
    );

    // The cell chain. Cell 0 sees a "less" neighbor on its left so that it
    // takes the key when the key belongs at the front. The last cell pulls
    // its own key on remove; that slot falls outside the count anyway.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_less;
        logic signed [KEY_W-1:0] right_key;

        assign valid[g] = g < int'(ctl.count);

        if (g == 0) begin : g_first
            assign left_key  = ctl.key;
            assign left_less = 1'b1;
        end else begin : g_inner
            assign left_key  = keys[g-1];
            assign left_less = less[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_end
            assign right_key = keys[g];
        end else begin : g_mid
            assign right_key = keys[g+1];
        end

        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_valid     (valid[g]),
            .i_left_key  (left_key),
            .i_left_less (left_less),
            .i_right_key (right_key),
            .o_key       (keys[g]),
            .o_less      (less[g]),
            .o_eq        (eq[g])
        );
    end

    // Only valid cells can match, so one OR gives the search answer.
    assign stat.found  = |eq;
    // One read port serves both read-at-index and the dump stream.
    assign stat.rd_key = keys[rd_addr];

endmodule

`default_nettype wire

@@ src/skt_checker.sv @@
// ============================================================================
// Sorted key table checker
// Watches the ports of the core and checks the handshakes and results of transactions.
// ============================================================================
`default_nettype none

module skt_checker
    import skt_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire t_in_item         i_in_item,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_out_item        o_out_item
);

    logic in_acc;
    logic single_cmd;
    logic unknown_cmd;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign single_cmd  = (i_in_item.cmd == CMD_INSERT) || (i_in_item.cmd == CMD_REMOVE) ||
                         (i_in_item.cmd == CMD_SEARCH) || (i_in_item.cmd == CMD_READ);
    assign unknown_cmd = !single_cmd && (i_in_item.cmd != CMD_DUMP);

    // A waiting result must hold off new commands.
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("command taken while a result is stalled");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // Single-result commands answer in the next cycle with last set.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && single_cmd) |=> (o_out_valid && o_out_item.last))
        else $error("single-result command gave no final result");

    // Unknown commands produce nothing.
    a_unknown_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && unknown_cmd) |=> !o_out_valid)
        else $error("unknown command produced a result");

    // The status code stays within its defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= STAT_BADPOS))
        else $error("undefined status code");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (.*);

`default_nettype wire
